>>> sv/lvs_pkg.sv
// lvs_pkg: shared widths, constants and types for the line voxel sampler
// no dependencies
`default_nettype none
package lvs_pkg;
  localparam int MaxStepsDef = 63;
  localparam int StepW = 17;
  localparam logic [16:0] StepReset = 17'd6554;
  localparam logic [16:0] StepMax = 17'd65536;
  localparam logic [32:0] BigMag = 33'h400000;

  typedef struct packed {
    logic start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> sv/line_voxel_sampler_3d_unit.sv
// line_voxel_sampler_3d_unit: fixed-step voxel walk along a 3d segment
// depends on lvs_pkg and lvs_div
// sequence: setup (shift search, squares, step count, integer square root),
//   then one division per axis on the shared divider, then one sampling step
//   per cycle plus a final word when the last step changes cell; when no step
//   fits, only the start cell is shown and the root and divisions are skipped
// throughput: one segment at a time, busy is high from the accepting edge until
//   the cycle that shows the last word
// the receiver cannot stall: each word is shown for one cycle with out_valid
// reset: synchronous, active high; clears the sequencer, step_length to 6554
`default_nettype none
module line_voxel_sampler_3d_unit #(
  parameter int MAX_STEPS = lvs_pkg::MaxStepsDef
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] end_z,
  input  logic cfg_we,
  input  logic [lvs_pkg::StepW-1:0] cfg_wdata,
  output logic out_valid,
  output logic signed [15:0] cell_x,
  output logic signed [15:0] cell_y,
  output logic signed [15:0] cell_z,
  output logic last,
  output logic truncated
);
  import lvs_pkg::*;

  localparam int KW = $clog2(MAX_STEPS + 2);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SHIFT = 9'b000000010,
    S_SQ    = 9'b000000100,
    S_CNT   = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_WALK  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;
  logic [16:0] step_length;
  logic [16:0] step;
  // per-axis working registers
  logic signed [47:0] pos [3];
  logic signed [32:0] d [3];
  logic [32:0] mag [3];
  logic signed [47:0] comp [3];
  logic signed [15:0] prev [3];
  logic [4:0] sh;
  logic [47:0] dsq;
  logic [1:0] ax;
  logic [KW-1:0] k;
  logic [KW-1:0] n;
  logic trunc;
  // square root state
  logic [63:0] sx, sres, sbit;
  logic [47:0] len;
  // shared multiplier operands
  logic [32:0] ma, mb;
  logic [65:0] mp;
  div_req_t dreq;
  div_rsp_t drsp;

  assign mp = ma * mb;
  assign busy = (state != S_IDLE);

  function automatic logic signed [15:0] cell_of(input logic signed [47:0] p);
    logic signed [31:0] c;
    c = 32'(p >>> 16);
    if (c > 32'sd32767) return 16'sh7fff;
    if (c < -32'sd32768) return 16'sh8000;
    return c[15:0];
  endfunction

  lvs_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic any_big;
  logic signed [47:0] npos [3];
  logic signed [15:0] ncell [3];
  always_comb begin
    any_big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((mag[i] >> sh) >= BigMag) any_big = 1'b1;
      npos[i] = pos[i] + comp[i];
      ncell[i] = cell_of(npos[i]);
    end
    ma = '0;
    mb = '0;
    case (state)
      S_SQ: begin
        ma = mag[ax] >> sh;
        mb = mag[ax] >> sh;
      end
      S_CNT: begin
        ma = 33'(k) * 33'(step);
        mb = 33'(k) * 33'(step);
      end
      S_DIV: begin
        ma = mag[ax] >> sh;
        mb = {8'd0, step, 8'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step_length <= StepReset;
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      dreq.start <= 1'b0;
      if (cfg_we) step_length <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (start) begin
            step <= (step_length == 17'd0) ? 17'd1 :
                    (step_length > StepMax) ? StepMax : step_length;
            pos[0] <= 48'(start_x);
            pos[1] <= 48'(start_y);
            pos[2] <= 48'(start_z);
            d[0] <= 33'(end_x) - 33'(start_x);
            d[1] <= 33'(end_y) - 33'(start_y);
            d[2] <= 33'(end_z) - 33'(start_z);
            prev[0] <= cell_of(48'(start_x));
            prev[1] <= cell_of(48'(start_y));
            prev[2] <= cell_of(48'(start_z));
            sh <= '0;
            dsq <= '0;
            ax <= '0;
            trunc <= 1'b0;
            state <= S_SHIFT;
            sbit <= 64'd0;
          end
        end
        S_SHIFT: begin
          if (sbit == 64'd0) begin
            for (int i = 0; i < 3; i++)
              mag[i] <= d[i][32] ? 33'(-d[i]) : d[i];
            sbit <= 64'd1;
          end else if (any_big) begin
            sh <= sh + 5'd1;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          dsq <= dsq + mp[47:0];
          if (ax == 2'd2) begin
            ax <= '0;
            k <= KW'(1);
            n <= '0;
            // root operand ready here for the saturated path that skips the count
            sx <= {dsq + mp[47:0], 16'd0};
            sres <= '0;
            if (sh != 5'd0) begin
              trunc <= 1'b1;
              n <= KW'(MAX_STEPS);
              state <= S_SQRT;
            end else state <= S_CNT;
            sbit <= 64'd1 << 62;
          end else ax <= ax + 2'd1;
        end
        S_CNT: begin
          if (mp > 66'(dsq) || k == KW'(MAX_STEPS + 1)) begin
            if (!(mp > 66'(dsq))) begin
              n <= KW'(MAX_STEPS);
              trunc <= 1'b1;
            end
            state <= S_SQRT;
          end else begin
            n <= k;
            k <= k + KW'(1);
          end
          sx <= {dsq, 16'd0};
          sres <= '0;
        end
        S_SQRT: begin
          if (n == '0) begin
            out_valid <= 1'b1;
            cell_x <= prev[0];
            cell_y <= prev[1];
            cell_z <= prev[2];
            last <= 1'b1;
            truncated <= trunc;
            state <= S_IDLE;
          end else if (sbit == 64'd0) begin
            // start cell stays pending in prev until the walk shows what follows
            len <= sres[47:0];
            state <= S_DIV;
          end else if (sbit > sx) begin
            sres <= sres >> 1;
            sbit <= sbit >> 2;
          end else begin
            if (sx >= sres + sbit) begin
              sx <= sx - (sres + sbit);
              sres <= (sres >> 1) + sbit;
            end else sres <= sres >> 1;
            sbit <= sbit >> 2;
          end
        end
        S_DIV: begin
          dreq.start <= 1'b1;
          dreq.num <= mp[63:0] + 64'(len >> 1);
          dreq.den <= len;
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (drsp.done) begin
            comp[ax] <= d[ax][32] ? -48'(drsp.quo) : 48'(drsp.quo);
            if (ax == 2'd2) begin
              k <= '0;
              state <= S_WALK;
            end else begin
              ax <= ax + 2'd1;
              state <= S_DIV;
            end
          end
        end
        S_WALK: begin
          // prev is the word not yet shown; it goes out once the next cell is
          // known, so last lands on the final word
          for (int i = 0; i < 3; i++) pos[i] <= npos[i];
          k <= k + KW'(1);
          if (ncell[0] != prev[0] || ncell[1] != prev[1] || ncell[2] != prev[2]) begin
            out_valid <= 1'b1;
            cell_x <= prev[0];
            cell_y <= prev[1];
            cell_z <= prev[2];
            last <= 1'b0;
            truncated <= trunc;
            for (int i = 0; i < 3; i++) prev[i] <= ncell[i];
            if (k + KW'(1) == n) state <= S_EMIT;
          end else if (k + KW'(1) == n) begin
            out_valid <= 1'b1;
            cell_x <= prev[0];
            cell_y <= prev[1];
            cell_z <= prev[2];
            last <= 1'b1;
            truncated <= trunc;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          // cell changed on the final step: that cell is the last word
          out_valid <= 1'b1;
          cell_x <= prev[0];
          cell_y <= prev[1];
          cell_z <= prev[2];
          last <= 1'b1;
          truncated <= trunc;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> sv/lvs_div.sv
// lvs_div: shared restoring divider, one quotient bit per cycle
// depends on lvs_pkg
`default_nettype none
module lvs_div (
  input  logic clk,
  input  logic rst,
  input  lvs_pkg::div_req_t req,
  output lvs_pkg::div_rsp_t rsp
);
  import lvs_pkg::*;
  logic [63:0] q;
  logic [48:0] rem;
  logic [47:0] den;
  logic [6:0] cnt;
  logic busy;
  logic done;
  logic [48:0] trial;

  always_comb begin
    trial = {rem[47:0], q[63]} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        q <= req.num;
        rem <= '0;
        den <= req.den;
        cnt <= 7'd64;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial;
          q <= {q[62:0], 1'b1};
        end else begin
          rem <= {rem[47:0], q[63]};
          q <= {q[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = '{done: done, quo: q};
endmodule
`default_nettype wire

>>> sv/lvs_checker.sv
// lvs_checker: port-level assertions for the line voxel sampler
// depends on line_voxel_sampler_3d_unit ports; bound below
`default_nettype none
module lvs_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic last,
  input logic truncated
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !busy) else $error("busy during last word");
  a_no_word_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(busy)) else $error("word while idle");
  a_trunc_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(last) |-> truncated == $past(truncated))
    else $error("truncated changed within a segment");
endmodule

bind line_voxel_sampler_3d_unit lvs_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .out_valid(out_valid), .last(last), .truncated(truncated)
);
`default_nettype wire

>>> tb/sv/tb.sv
// tb: self-checking bench for line_voxel_sampler_3d_unit, directed segments then random ones
// depends on lvs_pkg and the sampler rtl; predicts each voxel word (or takes a typed one) and checks it in order
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lvs_pkg::*;

  localparam int MaxSteps = 63;
  localparam int Cap = 63;
  localparam int SegLatency = 400;   // generous bound on one segment
  localparam int DogLimit = 6000;    // cycles without an accepted segment or a shown word
  localparam int RandItems = 220;

  typedef struct packed {
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
  } seg_t;

  typedef struct packed {
    logic signed [15:0] cx, cy, cz;
    logic lst;
    logic trn;
  } cell_word_t;

  // directed row: a segment, and a typed-in single word where it is obvious
  typedef struct {
    seg_t seg;
    bit typed;
    cell_word_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic cfg_we = 1'b0;
  logic [StepW-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [15:0] cell_x, cell_y, cell_z;
  logic last, truncated;

  always #4 clk = ~clk;

  line_voxel_sampler_3d_unit #(.MAX_STEPS(MaxSteps)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .last(last), .truncated(truncated)
  );

  // bench copy of the step register
  logic [StepW-1:0] step_reg = StepReset;
  cell_word_t pending_cells[$];
  int errors = 0;
  int segs_sent = 0;
  int words_seen = 0;
  int trunc_words = 0;
  int dog = 0;
  int idle_pct = 14;
  bit accepted_now = 0;

  // floor to voxel index, clamped into 16 bits
  function automatic longint voxel_of(longint p);
    longint c;
    c = p >>> 16;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return c;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= x) res = trial;
    end
    return res;
  endfunction

  // walk the segment the way the block does and queue the voxel words it should emit
  task automatic predict_voxels(seg_t s);
    longint pos[3], d[3], comp[3], cur[3], prev[3];
    longint unsigned mag[3], r[3], dsq, len, stp, ks, q;
    int sh, n, nout;
    bit big, trn, diff;
    cell_word_t w;
    stp = step_reg;
    if (stp == 0) stp = 1;
    if (stp > 65536) stp = 65536;
    pos[0] = s.sx; pos[1] = s.sy; pos[2] = s.sz;
    d[0] = longint'(s.ex) - pos[0];
    d[1] = longint'(s.ey) - pos[1];
    d[2] = longint'(s.ez) - pos[2];
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      prev[i] = voxel_of(pos[i]);
    end
    sh = 0;
    do begin
      big = 0;
      for (int i = 0; i < 3; i++) if ((mag[i] >> sh) >= 64'h400000) big = 1;
      if (big) sh++;
    end while (big);
    dsq = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = mag[i] >> sh;
      dsq += r[i] * r[i];
    end
    n = 0;
    trn = 0;
    if (sh > 0) begin
      trn = 1;
      n = MaxSteps;
    end else begin
      for (int k = 1; k <= MaxSteps + 1; k++) begin
        ks = k * stp;
        if (ks * ks > dsq) break;
        n = k;
      end
      if (n > MaxSteps) begin
        n = MaxSteps;
        trn = 1;
      end
    end
    w = '{cx: prev[0], cy: prev[1], cz: prev[2], lst: 1'b0, trn: trn};
    pending_cells.push_back(w);
    nout = 1;
    if (n > 0) begin
      len = root_floor(dsq << 16);
      for (int i = 0; i < 3; i++) begin
        q = (r[i] * stp * 256 + len / 2) / len;
        comp[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      end
      for (int k = 0; k < n; k++) begin
        diff = 0;
        for (int i = 0; i < 3; i++) begin
          pos[i] += comp[i];
          cur[i] = voxel_of(pos[i]);
          if (cur[i] != prev[i]) diff = 1;
        end
        if (diff) begin
          w = '{cx: cur[0], cy: cur[1], cz: cur[2], lst: 1'b0, trn: trn};
          pending_cells.push_back(w);
          nout++;
          prev = cur;
        end
      end
    end
    // mark the final word of this segment
    w = pending_cells[$];
    w.lst = 1'b1;
    pending_cells[$] = w;
  endtask

  // hand one segment to the block; typed rows queue their own word instead of the prediction
  task automatic send_segment(seg_t s, bit typed, cell_word_t want);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start_x <= s.sx; start_y <= s.sy; start_z <= s.sz;
    end_x <= s.ex; end_y <= s.ey; end_z <= s.ez;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // accepted at this edge
    if (typed) pending_cells.push_back(want);
    else predict_voxels(s);
    segs_sent++;
    accepted_now = 1;
  endtask

  // wait for every word of the queued segments, then for the block to settle
  task automatic drain_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_step(logic [StepW-1:0] v);
    drain_block();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_reg = v;
  endtask

  // short segment of up to several dozen steps, kept well inside the coordinate range
  function automatic seg_t short_seg();
    seg_t s;
    longint base[3], dl;
    longint span;
    span = longint'(step_reg == 0 ? 1 : step_reg) * $urandom_range(1, 80);
    for (int i = 0; i < 3; i++) begin
      base[i] = $urandom_range(3) == 0 ? longint'($signed($urandom)) >>> 1
                                       : longint'($signed($urandom_range(0, 2000000))) - 1000000;
    end
    s.sx = base[0]; s.sy = base[1]; s.sz = base[2];
    dl = longint'($urandom_range(0, 32'(span))) - span / 2; s.ex = base[0] + dl;
    dl = longint'($urandom_range(0, 32'(span))) - span / 2; s.ey = base[1] + dl;
    dl = longint'($urandom_range(0, 32'(span))) - span / 2; s.ez = base[2] + dl;
    return s;
  endfunction

  function automatic seg_t any_seg();
    seg_t s;
    s = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return s;
  endfunction

  // segment hugging the top or bottom of the range, where the walk may leave 16 bits
  function automatic seg_t edge_seg();
    seg_t s;
    bit up;
    up = $urandom_range(1);
    s = short_seg();
    if (up) begin
      s.sx = 32'h7FFF0000 + $urandom_range(0, 16'hFFFF);
      s.ex = 32'h7FFFFFFF - $urandom_range(0, 255);
    end else begin
      s.sx = 32'h80000000 + $urandom_range(0, 16'hFFFF);
      s.ex = 32'h80000000 + $urandom_range(0, 255);
    end
    return s;
  endfunction

  // result checker: the receiver never stalls, so every strobed word is taken
  always @(posedge clk) begin
    cell_word_t got, exp_w;
    if (!rst && out_valid) begin
      got = '{cx: cell_x, cy: cell_y, cz: cell_z, lst: last, trn: truncated};
      words_seen++;
      if (truncated) trunc_words++;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected voxel word %p", $time, got);
        errors++;
      end else begin
        exp_w = pending_cells.pop_front();
        if (got.cx !== exp_w.cx || got.cy !== exp_w.cy || got.cz !== exp_w.cz) begin
          $display("%0t: cell mismatch expected (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
                   exp_w.cx, exp_w.cy, exp_w.cz, got.cx, got.cy, got.cz);
          errors++;
        end
        if (got.lst !== exp_w.lst) begin
          $display("%0t: last mismatch expected %0b got %0b", $time, exp_w.lst, got.lst);
          errors++;
        end
        if (got.trn !== exp_w.trn) begin
          $display("%0t: truncated mismatch expected %0b got %0b", $time, exp_w.trn, got.trn);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles in which neither a segment nor a word moves
  always @(posedge clk) begin
    if (rst || out_valid || accepted_now) dog <= 0;
    else dog <= dog + 1;
    accepted_now = 0;
    if (dog >= DogLimit) begin
      $display("%0t: watchdog expired, %0d words still due", $time, pending_cells.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  row_t rows[$];
  logic [StepW-1:0] step_plan[6] = '{17'd1, 17'd65536, 17'd0, 17'd131071, 17'd3000, 17'd20000};

  initial begin
    cell_word_t none;
    none = '0;
    // directed rows; zero-length and sub-step ones give one obvious word
    rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1, 0}});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000}, 1,
                     '{-16'sd32768, -16'sd32768, -16'sd32768, 1, 0}});
    rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1,
                     '{16'sd32767, 16'sd32767, 16'sd32767, 1, 0}});
    rows.push_back('{'{32'h1234, 0, 0, 32'h1300, 0, 0}, 1, '{0, 0, 0, 1, 0}});
    rows.push_back('{'{0, 0, 0, 32'h10000, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, 0, -32'sh30000, -32'sh20000, 32'h8000}, 0, none});
    rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 0, none});
    rows.push_back('{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h80000000, 32'h80000000}, 0, none});
    rows.push_back('{'{0, 0, 0, 32'h400000, 0, 0}, 0, none});
    rows.push_back('{'{0, 0, 0, 0, 0, 32'h3FFFFF}, 0, none});
    rows.push_back('{'{32'h7FFE0000, 0, 0, 32'h7FFFFFFF, 0, 0}, 0, none});
    rows.push_back('{'{-1, -1, -1, -32'sh18000, 32'h8000, -1}, 0, none});
    rows.push_back('{'{32'h18000, -32'sh28000, 32'h4000, 32'h48000, 32'h8000, -32'sh24000}, 0, none});
    rows.push_back('{'{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F,
                       32'h55565555, 32'hAAA9AAAA, 32'h0F0F8F0F}, 0, none});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset step, written once explicitly
    write_step(StepReset);
    foreach (rows[i]) send_segment(rows[i].seg, rows[i].typed, rows[i].want);

    // random part, step register swept between phases
    for (int i = 0; i < RandItems; i++) begin
      seg_t s;
      int pick;
      if (i % 32 == 0) write_step(step_plan[(i / 32) % 6]);
      // sender idling: light, then heavy, then none
      idle_pct = i < RandItems / 3 ? 14 : (i < 2 * RandItems / 3 ? 70 : 0);
      // hold off once until the block has emptied out
      if (i == 100) drain_block();
      pick = $urandom_range(99);
      if (pick < 70) s = short_seg();
      else if (pick < 85) s = any_seg();
      else s = edge_seg();
      send_segment(s, 0, none);
    end

    drain_block();
    repeat (SegLatency / 20) @(posedge clk);
    $display("covered %0d segments over 7 step settings, %0d voxel words (%0d truncated)",
             segs_sent, words_seen, trunc_words);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
